FILE: rtl/sss_pkg.sv
// Package with shared widths, constants and register codes for the servo ramp.
`timescale 1ns / 1ps
package sss_pkg;

	// Field widths of the item channels and registers
	localparam int ANGLE_W   = 12;
	localparam int PULSE_W   = 12;
	localparam int STEP_W    = 8;
	localparam int TGT_IN_W  = 14;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// Angle and pulse constants, in whole degrees and microseconds
	localparam int DEG_MAX_TARGET = 120;
	localparam int DEG_FULL_SCALE = 180;
	localparam int DEG_RESET      = 90;
	localparam int PULSE_BASE_US  = 500;
	localparam int PULSE_SPAN_US  = 2000;

	// Register reset values
	localparam logic [STEP_W-1:0]  STEP_RST        = 8'd16;
	localparam logic [ANGLE_W-1:0] SWING_LEFT_RST  = 12'd960;
	localparam logic [ANGLE_W-1:0] SWING_RIGHT_RST = 12'd1920;

	// Register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_STEP        = 2'd0;
	localparam logic [1:0] REG_SWING_LEFT  = 2'd1;
	localparam logic [1:0] REG_SWING_RIGHT = 2'd2;
	localparam logic [1:0] REG_SWING_MODE  = 2'd3;

	// Request codes
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_TARGET = 1'b1;

endpackage

FILE: rtl/sss_if.sv
// Valid/ready channel interfaces for request items and result items.
`timescale 1ns / 1ps
interface sss_req_if import sss_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic signed [TGT_IN_W-1:0] target_angle_q4;

	modport source (output valid, output req_type, output target_angle_q4, input ready);
	modport sink (input valid, input req_type, input target_angle_q4, output ready);
endinterface

interface sss_res_if import sss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle_q4;
	logic [PULSE_W-1:0] pulse_us;

	modport source (output valid, output angle_q4, output pulse_us, input ready);
	modport sink (input valid, input angle_q4, input pulse_us, output ready);
endinterface

FILE: rtl/servo_slew_and_swing.sv
// Servo position ramp with target slewing and a sweep between two limits.
// A tick item's result passes the input register, then the result register.
// Throughput: one item per cycle while results are taken; the result register frees
// the input side as soon as the held result is taken in the same cycle. A set-target
// item gives no result, nor does a tick while no motion is enabled.
// Reset (arst_n low) returns all but the payload registers to reset, angle 90 degrees.
`timescale 1ns / 1ps
module servo_slew_and_swing import sss_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	sss_req_if.sink            req,
	sss_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	// Scaled angle limits and widths
	localparam int TGT_MAX  = DEG_MAX_TARGET << ANGLE_FRAC_BITS;
	localparam int RST_ANG  = DEG_RESET << ANGLE_FRAC_BITS;
	localparam int FULL     = DEG_FULL_SCALE << ANGLE_FRAC_BITS;
	localparam int TGT_W    = $clog2(TGT_MAX + 1);
	localparam int CUR_W    = (TGT_W > ANGLE_W) ? TGT_W : ANGLE_W;
	localparam int CW       = ((CUR_W > TGT_IN_W) ? CUR_W : TGT_IN_W) + 2;
	// Pulse scaling: floor(a*SPAN/FULL) as a*MUL >> MUL_FRAC
	localparam int MUL_FRAC = 32;
	localparam longint unsigned PULSE_MUL =
		((64'(PULSE_SPAN_US) << MUL_FRAC) + 64'(FULL) - 64'd1) / 64'(FULL);
	localparam int MUL_W    = $clog2(PULSE_MUL + 1);
	localparam int PW       = MUL_FRAC + ANGLE_W + MUL_W;

	// Configuration registers
	logic [STEP_W-1:0]  step_q;
	logic [ANGLE_W-1:0] swing_left_q;
	logic [ANGLE_W-1:0] swing_right_q;
	logic               swing_mode_q;

	// Ramp state
	logic [CUR_W-1:0]   cur_angle_q;
	logic [TGT_W-1:0]   tgt_angle_q;
	logic               motion_en_q;
	logic               sweep_right_q;

	// Input stage
	logic                       valid_s1;
	logic                       req_type_s1;
	logic signed [TGT_IN_W-1:0] tgt_in_s1;

	// Result register
	logic               res_valid_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [PULSE_W-1:0] pulse_q;

	logic               cfg_wr;
	logic               advance;
	logic               emit;
	logic signed [CW-1:0] cur_x, tgt_x, step_x, lim_l_x, lim_r_x, req_x, nxt_x, tgt_clamp_x;
	logic [CUR_W-1:0]   cur_d;
	logic               motion_en_d;
	logic               sweep_right_d;
	logic [ANGLE_W-1:0] ang_res;
	logic [PW-1:0]      prod;
	logic [PULSE_W-1:0] pulse_d;

	// APB write and read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_STEP:        prdata = APB_DW'(step_q);
			REG_SWING_LEFT:  prdata = APB_DW'(swing_left_q);
			REG_SWING_RIGHT: prdata = APB_DW'(swing_right_q);
			REG_SWING_MODE:  prdata = APB_DW'(swing_mode_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= STEP_RST;
			swing_left_q  <= SWING_LEFT_RST;
			swing_right_q <= SWING_RIGHT_RST;
			swing_mode_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_STEP:        step_q        <= pwdata[STEP_W-1:0];
				REG_SWING_LEFT:  swing_left_q  <= pwdata[ANGLE_W-1:0];
				REG_SWING_RIGHT: swing_right_q <= pwdata[ANGLE_W-1:0];
				REG_SWING_MODE:  swing_mode_q  <= pwdata[0];
				default:         ;
			endcase
		end
	end

	// Handshake: the stage advances whenever the result register can take a result
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign emit      = advance && (req_type_s1 == REQ_TICK) && motion_en_q;

	// Capture the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			tgt_in_s1   <= req.target_angle_q4;
		end
	end

	// Clamp a requested target into 0..120 degrees
	always_comb begin
		req_x = CW'(tgt_in_s1);
		if (req_x < 0) begin
			tgt_clamp_x = '0;
		end else if (req_x > CW'(TGT_MAX)) begin
			tgt_clamp_x = CW'(TGT_MAX);
		end else begin
			tgt_clamp_x = req_x;
		end
	end

	// Step the position for an active tick
	always_comb begin
		cur_x         = CW'(cur_angle_q);
		tgt_x         = CW'(tgt_angle_q);
		step_x        = CW'(step_q);
		lim_l_x       = CW'(swing_left_q);
		lim_r_x       = CW'(swing_right_q);
		nxt_x         = cur_x;
		motion_en_d   = motion_en_q;
		sweep_right_d = sweep_right_q;
		if (swing_mode_q) begin
			if (sweep_right_q) begin
				nxt_x = cur_x + step_x;
				if (nxt_x >= lim_r_x) begin
					nxt_x         = lim_r_x;
					sweep_right_d = 1'b0;
				end
			end else begin
				nxt_x = cur_x - step_x;
				if (nxt_x <= lim_l_x) begin
					nxt_x         = lim_l_x;
					sweep_right_d = 1'b1;
				end
			end
		end else begin
			if (cur_x < tgt_x) begin
				nxt_x = cur_x + step_x;
				if (nxt_x > tgt_x) nxt_x = tgt_x;
			end else if (cur_x > tgt_x) begin
				nxt_x = cur_x - step_x;
				if (nxt_x < tgt_x) nxt_x = tgt_x;
			end
			if (nxt_x == tgt_x) motion_en_d = 1'b0;
		end
		cur_d = nxt_x[CUR_W-1:0];
	end

	// Scale the angle into a pulse width
	assign ang_res = cur_d[ANGLE_W-1:0];
	assign prod    = PW'(ang_res) * PW'(PULSE_MUL);
	assign pulse_d = prod[MUL_FRAC +: PULSE_W] + PULSE_W'(PULSE_BASE_US);

	// Update the ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_angle_q   <= CUR_W'(RST_ANG);
			tgt_angle_q   <= TGT_W'(RST_ANG);
			motion_en_q   <= 1'b0;
			sweep_right_q <= 1'b1;
		end else if (advance) begin
			if (req_type_s1 == REQ_TARGET) begin
				tgt_angle_q <= tgt_clamp_x[TGT_W-1:0];
				motion_en_q <= 1'b1;
			end else if (motion_en_q) begin
				cur_angle_q   <= cur_d;
				motion_en_q   <= motion_en_d;
				sweep_right_q <= sweep_right_d;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			angle_q <= ang_res;
			pulse_q <= pulse_d;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.angle_q4 = angle_q;
	assign res.pulse_us = pulse_q;

endmodule

FILE: rtl/sss_checker.sv
// Port-level checks for the servo ramp, bound to the top level.
`timescale 1ns / 1ps
module sss_checker import sss_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               req_type,
	input logic               res_valid,
	input logic               res_ready,
	input logic [ANGLE_W-1:0] angle_q4,
	input logic [PULSE_W-1:0] pulse_us
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(angle_q4) && $stable(pulse_us))
		else $error("result payload changed while stalled");

	// A fresh result comes from an earlier accepted item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result without an accepted item");

	// A set-target item never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_type == REQ_TICK, 2))
		else $error("result from a set-target item");

endmodule

bind servo_slew_and_swing sss_checker u_sss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.angle_q4  (res.angle_q4),
	.pulse_us  (res.pulse_us)
);
